### rtl/core/nfb_pkg.sv
// ----------------------------------------------------------------------------
// nfb_pkg
// Shared types, widths and helpers of the 4bpp framebuffer draw engine.
// ----------------------------------------------------------------------------
package nfb_pkg;

  localparam int DEF_MAX_WIDTH = 256;
  localparam int DEF_MAX_LINES = 64;

  // Field widths
  localparam int OP_W       = 3;
  localparam int X_W        = 8;
  localparam int Y_W        = 6;
  localparam int XL_W       = 9;
  localparam int YL_W       = 7;
  localparam int COLOR_W    = 4;
  localparam int BYTE_W     = 8;
  localparam int FW_W       = 9;
  localparam int FL_W       = 7;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 9;

  // Internal widths
  localparam int PX_X_W    = 10;  // origin x plus bitmap column
  localparam int PX_Y_W    = 8;   // origin y plus bitmap row
  localparam int CUR_COL_W = 9;
  localparam int CUR_ROW_W = 7;
  localparam int ITER_W    = 9;
  localparam int BPL_W     = 9;
  localparam int PROD_W    = PX_Y_W + BPL_W;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LINES = 4'd1;

  typedef enum logic [OP_W-1:0] {
    OP_PIXEL = 3'd0,
    OP_FILL  = 3'd1,
    OP_HLINE = 3'd2,
    OP_VLINE = 3'd3,
    OP_BMP4  = 3'd4,
    OP_BMP8  = 3'd5,
    OP_READ  = 3'd6
  } op_t;

  typedef struct packed {
    logic capture;
    logic cursor_clear;
    logic line_init;
    logic line_step;
    logic line_load;
    logic bmp_step;
    logic nib_next;
    logic pix_load;
    logic prod_load;
    logic rd_issue;
    logic rd_capture;
    logic px_write;
    logic clip_set;
    logic fill_clear;
    logic fill_write;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic first;
    logic in_frame;
    logic line_more;
    logic bmp_draw;
    logic nib_sel;
    logic fill_last;
  } dp_stat_t;

  function automatic int store_depth(input int max_width, input int max_lines);
    return max_lines * ((max_width + 1) / 2);
  endfunction

  function automatic int addr_width(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

### rtl/core/nfb_ram.sv
// ----------------------------------------------------------------------------
// nfb_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module nfb_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 8192,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/nfb_dpath.sv
// ----------------------------------------------------------------------------
// nfb_dpath
// Datapath: operand and cursor registers, frame check, address generation,
// nibble merge and the result registers.
// ----------------------------------------------------------------------------
module nfb_dpath #(
  parameter int MAX_WIDTH = nfb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_LINES = nfb_pkg::DEF_MAX_LINES,
  parameter int DEPTH     = nfb_pkg::store_depth(MAX_WIDTH, MAX_LINES),
  parameter int ADDR_W    = nfb_pkg::addr_width(DEPTH)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [nfb_pkg::OP_W-1:0]            in_op,
  input  logic [nfb_pkg::X_W-1:0]             in_x_pos,
  input  logic [nfb_pkg::Y_W-1:0]             in_y_pos,
  input  logic [nfb_pkg::XL_W-1:0]            in_x_limit,
  input  logic [nfb_pkg::YL_W-1:0]            in_y_limit,
  input  logic [nfb_pkg::COLOR_W-1:0]         in_color,
  input  logic [nfb_pkg::BYTE_W-1:0]          in_data_byte,
  input  logic                                in_first_byte,
  input  logic                                cfg_wr_en,
  input  logic [nfb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [nfb_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  nfb_pkg::dp_cmd_t                    cmd,
  output nfb_pkg::dp_stat_t                   stat,
  output logic                                ram_we,
  output logic [ADDR_W-1:0]                   ram_waddr,
  output logic [nfb_pkg::BYTE_W-1:0]          ram_wdata,
  output logic                                ram_re,
  output logic [ADDR_W-1:0]                   ram_raddr,
  input  logic [nfb_pkg::BYTE_W-1:0]          ram_rdata,
  output logic [nfb_pkg::BYTE_W-1:0]          out_read_byte,
  output logic                                out_clipped
);

  import nfb_pkg::*;

  localparam int W_RST = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
  localparam int L_RST = (MAX_LINES < 64) ? MAX_LINES : 64;
  localparam logic [FW_W-1:0]   W_RST_V   = FW_W'(W_RST);
  localparam logic [BPL_W-1:0]  BPL_RST_V = BPL_W'((W_RST + 1) / 2);
  localparam logic [FL_W-1:0]   L_RST_V   = FL_W'(L_RST);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  // Configuration (saturated on write)
  logic [FW_W-1:0]  w_eff_r;
  logic [BPL_W-1:0] bpl_r;
  logic [FL_W-1:0]  l_eff_r;
  logic [FW_W-1:0]  w_sat;
  logic [FW_W:0]    w_sum;
  logic [FL_W-1:0]  l_sat;

  // Captured item
  op_t                op_r;
  logic [X_W-1:0]     x_r;
  logic [Y_W-1:0]     y_r;
  logic [XL_W-1:0]    xl_r;
  logic [YL_W-1:0]    yl_r;
  logic [COLOR_W-1:0] color_r;
  logic [BYTE_W-1:0]  data_r;
  logic               first_r;

  // Working state
  logic [CUR_COL_W-1:0] col_r;
  logic [CUR_ROW_W-1:0] row_r;
  logic                 nib_sel_r;
  logic [ITER_W-1:0]    iter_r;
  logic [PX_X_W-1:0]    px_x_r;
  logic [PX_Y_W-1:0]    px_y_r;
  logic [COLOR_W-1:0]   pcolor_r;
  logic [PROD_W-1:0]    prod_r;
  logic [BPL_W-1:0]     xh_r;
  logic                 odd_r;
  logic [ADDR_W-1:0]    addr_r;
  logic [ADDR_W-1:0]    fill_cnt_r;
  logic                 clip_r;
  logic [BYTE_W-1:0]    rd_r;
  logic [BYTE_W-1:0]    out_read_byte_r;
  logic                 out_clipped_r;

  // Bitmap cursor step
  logic                 done0, wrap0, done1, bmp_draw;
  logic [CUR_COL_W-1:0] col_a, col_inc, col_n;
  logic [CUR_ROW_W-1:0] row_a, row_n;
  logic [PX_X_W-1:0]    bmp_x;
  logic [PX_Y_W-1:0]    bmp_y;
  logic [COLOR_W-1:0]   bmp_color;

  logic [ITER_W-1:0]    line_end;
  logic                 in_frame;
  logic [PROD_W:0]      addr_sum;

  assign w_sat = (int'(cfg_wdata) > MAX_WIDTH) ? FW_W'(MAX_WIDTH) : cfg_wdata;
  assign w_sum = {1'b0, w_sat} + {{FW_W{1'b0}}, 1'b1};
  assign l_sat = (int'(cfg_wdata[FL_W-1:0]) > MAX_LINES) ? FL_W'(MAX_LINES)
                                                         : cfg_wdata[FL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_eff_r <= W_RST_V;
      bpl_r   <= BPL_RST_V;
      l_eff_r <= L_RST_V;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FRAME_WIDTH: begin
          w_eff_r <= w_sat;
          bpl_r   <= w_sum[FW_W:1];
        end
        CFG_FRAME_LINES: l_eff_r <= l_sat;
        default: ;
      endcase
    end
  end

  always_comb begin
    done0     = (xl_r == '0) || (row_r >= yl_r);
    wrap0     = !done0 && (col_r >= xl_r);
    col_a     = wrap0 ? '0 : col_r;
    row_a     = wrap0 ? row_r + CUR_ROW_W'(1) : row_r;
    done1     = wrap0 && (row_a >= yl_r);
    bmp_draw  = !done0 && !done1;
    col_inc   = col_a + CUR_COL_W'(1);
    if (col_inc >= xl_r) begin
      col_n = '0;
      row_n = row_a + CUR_ROW_W'(1);
    end else begin
      col_n = col_inc;
      row_n = row_a;
    end
    bmp_x     = PX_X_W'(x_r) + PX_X_W'(col_a);
    bmp_y     = PX_Y_W'(y_r) + PX_Y_W'(row_a);
    bmp_color = nib_sel_r ? data_r[3:0] : data_r[7:4];
  end

  assign line_end = (op_r == OP_HLINE) ? xl_r : ITER_W'(yl_r);
  assign in_frame = (px_x_r < PX_X_W'(w_eff_r)) && (px_y_r < PX_Y_W'(l_eff_r));
  assign addr_sum = {1'b0, prod_r} + (PROD_W + 1)'(xh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.cursor_clear) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.bmp_step && !done0) begin
      col_r <= done1 ? col_a : col_n;
      row_r <= done1 ? row_a : row_n;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r      <= op_t'(in_op);
      x_r       <= in_x_pos;
      y_r       <= in_y_pos;
      xl_r      <= in_x_limit;
      yl_r      <= in_y_limit;
      color_r   <= in_color;
      data_r    <= in_data_byte;
      first_r   <= in_first_byte;
      clip_r    <= 1'b0;
      rd_r      <= '0;
      nib_sel_r <= 1'b0;
    end else begin
      if (cmd.clip_set) begin
        clip_r <= 1'b1;
      end
      if (cmd.rd_capture) begin
        rd_r <= ram_rdata;
      end
      if (cmd.nib_next) begin
        nib_sel_r <= 1'b1;
      end
    end

    if (cmd.line_init) begin
      iter_r <= (op_r == OP_HLINE) ? ITER_W'(x_r) : ITER_W'(y_r);
    end else if (cmd.line_step) begin
      iter_r <= iter_r + ITER_W'(1);
    end

    if (cmd.pix_load) begin
      px_x_r   <= PX_X_W'(x_r);
      px_y_r   <= PX_Y_W'(y_r);
      pcolor_r <= color_r;
    end else if (cmd.line_load) begin
      px_x_r   <= (op_r == OP_HLINE) ? PX_X_W'(iter_r) : PX_X_W'(x_r);
      px_y_r   <= (op_r == OP_HLINE) ? PX_Y_W'(y_r) : PX_Y_W'(iter_r);
      pcolor_r <= color_r;
    end else if (cmd.bmp_step && bmp_draw) begin
      px_x_r   <= bmp_x;
      px_y_r   <= bmp_y;
      pcolor_r <= bmp_color;
    end

    if (cmd.prod_load) begin
      prod_r <= PROD_W'(px_y_r) * PROD_W'(bpl_r);
      xh_r   <= px_x_r[PX_X_W-1:1];
      odd_r  <= px_x_r[0];
    end

    if (cmd.rd_issue) begin
      addr_r <= ADDR_W'(addr_sum);
    end

    if (cmd.fill_clear) begin
      fill_cnt_r <= '0;
    end else if (cmd.fill_write) begin
      fill_cnt_r <= fill_cnt_r + ADDR_W'(1);
    end

    if (cmd.out_load) begin
      out_read_byte_r <= rd_r;
      out_clipped_r   <= clip_r;
    end
  end

  // Memory port
  assign ram_re    = cmd.rd_issue;
  assign ram_raddr = ADDR_W'(addr_sum);
  assign ram_we    = cmd.px_write || cmd.fill_write;
  assign ram_waddr = cmd.fill_write ? fill_cnt_r : addr_r;
  always_comb begin
    if (cmd.fill_write) begin
      ram_wdata = {color_r, color_r};
    end else if (odd_r) begin
      ram_wdata = {ram_rdata[7:4], pcolor_r};
    end else begin
      ram_wdata = {pcolor_r, ram_rdata[3:0]};
    end
  end

  assign stat.op        = op_r;
  assign stat.first     = first_r;
  assign stat.in_frame  = in_frame;
  assign stat.line_more = iter_r < line_end;
  assign stat.bmp_draw  = bmp_draw;
  assign stat.nib_sel   = nib_sel_r;
  assign stat.fill_last = fill_cnt_r == LAST_ADDR;

  assign out_read_byte = out_read_byte_r;
  assign out_clipped   = out_clipped_r;

endmodule

### rtl/core/nfb_ctrl.sv
// ----------------------------------------------------------------------------
// nfb_ctrl
// Controller: sequences each operation over the datapath and owns both
// channel handshakes.
// ----------------------------------------------------------------------------
module nfb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  nfb_pkg::dp_stat_t stat,
  output nfb_pkg::dp_cmd_t  cmd
);

  import nfb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_LINE_CHK,
    S_BMP_STEP,
    S_LOCATE,
    S_RD,
    S_MERGE,
    S_NEXT,
    S_FILL,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.op)
          OP_PIXEL, OP_READ: begin
            cmd.pix_load = 1'b1;
            state_nxt    = S_LOCATE;
          end
          OP_FILL: begin
            cmd.fill_clear = 1'b1;
            state_nxt      = S_FILL;
          end
          OP_HLINE, OP_VLINE: begin
            cmd.line_init = 1'b1;
            state_nxt     = S_LINE_CHK;
          end
          OP_BMP4, OP_BMP8: begin
            cmd.cursor_clear = stat.first;
            state_nxt        = S_BMP_STEP;
          end
          default: state_nxt = S_FINISH;
        endcase
      end
      S_LINE_CHK: begin
        if (stat.line_more) begin
          cmd.line_load = 1'b1;
          state_nxt     = S_LOCATE;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_BMP_STEP: begin
        cmd.bmp_step = 1'b1;
        state_nxt    = stat.bmp_draw ? S_LOCATE : S_NEXT;
      end
      S_LOCATE: begin
        if (stat.in_frame) begin
          cmd.prod_load = 1'b1;
          state_nxt     = S_RD;
        end else begin
          cmd.clip_set = 1'b1;
          state_nxt    = S_NEXT;
        end
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_MERGE;
      end
      S_MERGE: begin
        if (stat.op == OP_READ) begin
          cmd.rd_capture = 1'b1;
          state_nxt      = S_FINISH;
        end else begin
          cmd.px_write = 1'b1;
          state_nxt    = S_NEXT;
        end
      end
      S_NEXT: begin
        case (stat.op)
          OP_HLINE, OP_VLINE: begin
            cmd.line_step = 1'b1;
            state_nxt     = S_LINE_CHK;
          end
          OP_BMP4: begin
            if (!stat.nib_sel) begin
              cmd.nib_next = 1'b1;
              state_nxt    = S_BMP_STEP;
            end else begin
              state_nxt = S_FINISH;
            end
          end
          default: state_nxt = S_FINISH;
        endcase
      end
      S_FILL: begin
        cmd.fill_write = 1'b1;
        if (stat.fill_last) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

endmodule

### rtl/core/nibble_framebuffer_draw_engine_unit.sv
// ----------------------------------------------------------------------------
// nibble_framebuffer_draw_engine_unit
// Packed 4-bit-per-pixel framebuffer with pixel, fill, line, bitmap and read
// operations.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one operation per transfer;
//   every operation returns exactly one result on out_valid/out_ready
//   (read_byte, clipped). Configuration writes on cfg_wr_en take effect at
//   once; the user must make them only while the engine is idle, as the
//   block itself does not enforce this. Operations run one at a time. Each
//   stored pixel passes coordinate step, frame check with y times bytes per
//   line, address add and memory read, nibble merge and write, and advance;
//   a clipped pixel or read skips the address, read and merge steps.
//   Fill: one byte a cycle over all MAX_LINES*((MAX_WIDTH+1)/2) bytes.
//   The result sits in an output register; a new operation is accepted
//   while it waits, and the next result holds in the engine until the
//   receiver takes the previous one.
//   Reset clears the controller, the bitmap cursor and the frame size
//   (256 by 64, saturated to the maximums). Memory contents are undefined
//   until written or filled.
// ----------------------------------------------------------------------------
module nibble_framebuffer_draw_engine_unit #(
  parameter int MAX_WIDTH = nfb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_LINES = nfb_pkg::DEF_MAX_LINES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [nfb_pkg::OP_W-1:0]       in_op,
  input  logic [nfb_pkg::X_W-1:0]        in_x_pos,
  input  logic [nfb_pkg::Y_W-1:0]        in_y_pos,
  input  logic [nfb_pkg::XL_W-1:0]       in_x_limit,
  input  logic [nfb_pkg::YL_W-1:0]       in_y_limit,
  input  logic [nfb_pkg::COLOR_W-1:0]    in_color,
  input  logic [nfb_pkg::BYTE_W-1:0]     in_data_byte,
  input  logic                           in_first_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [nfb_pkg::BYTE_W-1:0]     out_read_byte,
  output logic                           out_clipped,
  input  logic                           cfg_wr_en,
  input  logic [nfb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nfb_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import nfb_pkg::*;

  localparam int DEPTH  = store_depth(MAX_WIDTH, MAX_LINES);
  localparam int ADDR_W = addr_width(DEPTH);

  dp_cmd_t             cmd;
  dp_stat_t            stat;
  logic                ram_we;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [BYTE_W-1:0]   ram_wdata;
  logic [BYTE_W-1:0]   ram_rdata;

  nfb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  nfb_dpath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_LINES (MAX_LINES),
    .DEPTH     (DEPTH),
    .ADDR_W    (ADDR_W)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_op         (in_op),
    .in_x_pos      (in_x_pos),
    .in_y_pos      (in_y_pos),
    .in_x_limit    (in_x_limit),
    .in_y_limit    (in_y_limit),
    .in_color      (in_color),
    .in_data_byte  (in_data_byte),
    .in_first_byte (in_first_byte),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .cmd           (cmd),
    .stat          (stat),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_re        (ram_re),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata),
    .out_read_byte (out_read_byte),
    .out_clipped   (out_clipped)
  );

  nfb_ram #(
    .WIDTH  (BYTE_W),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // A clipped result never carries read data
  a_clip_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |-> out_read_byte == '0)
    else $error("clipped result with nonzero read_byte");

  // Read and write of the store never share a cycle
  a_ram_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("store read and write in the same cycle");

  // No store write or result load while a new item is being taken in
  a_no_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !ram_we && !cmd.out_load)
    else $error("store write or result load during input transfer");

  // A result is loaded only into a free or draining output register
  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !out_valid || out_ready)
    else $error("result overwritten before transfer");

endmodule
